/* hw/rtl/ptd_pkg.sv */
// shared types and constants for the periodic task dispatcher
`timescale 1ns / 1ps

package ptd_pkg;

  localparam int TICK_W = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_PERIOD_BASE = 4;

  localparam logic [2:0] CMD_INIT   = 3'd0;
  localparam logic [2:0] CMD_TICK   = 3'd1;
  localparam logic [2:0] CMD_RUN    = 3'd2;
  localparam logic [2:0] CMD_ACT    = 3'd3;
  localparam logic [2:0] CMD_DEACT  = 3'd4;

  typedef struct packed {
    logic [2:0] cmd;
    logic [1:0] task_index;
  } in_req_t;

  typedef struct packed {
    logic [1:0] task_index_out;
    logic       due;
    logic       last;
    logic       fault;
  } out_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FAULT
  } ptd_state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;
    logic do_init;
    logic do_tick;
    logic do_run;
    logic do_act;
    logic do_deact;
    logic emit_hit;
    logic emit_idle;
    logic emit_fault;
  } ptd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       halted;
    logic       initialized;
    logic       mask_empty;
    logic       mask_last;
    logic       out_free;
  } ptd_stat_t;

endpackage

/* hw/rtl/ptd_ctrl.sv */
// controller state machine of the periodic task dispatcher
`timescale 1ns / 1ps

module ptd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ptd_pkg::ptd_stat_t stat,
  output ptd_pkg::ptd_cmd_t  ctl
);

  ptd_pkg::ptd_state_t state_r, state_nxt;
  logic misuse;

  always_comb begin
    misuse = stat.halted;
    unique case (stat.cmd)
      ptd_pkg::CMD_INIT: begin
        if (stat.initialized) misuse = 1'b1;
      end
      ptd_pkg::CMD_TICK, ptd_pkg::CMD_RUN, ptd_pkg::CMD_ACT: begin
        if (!stat.initialized) misuse = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptd_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = ptd_pkg::ST_EXEC;
      end
      ptd_pkg::ST_EXEC: begin
        if (misuse) state_nxt = ptd_pkg::ST_FAULT;
        else if (stat.cmd == ptd_pkg::CMD_RUN) state_nxt = ptd_pkg::ST_SCAN;
        else state_nxt = ptd_pkg::ST_IDLE;
      end
      ptd_pkg::ST_SCAN: begin
        if (stat.out_free && (stat.mask_empty || stat.mask_last)) begin
          state_nxt = ptd_pkg::ST_IDLE;
        end
      end
      ptd_pkg::ST_FAULT: begin
        if (stat.out_free) state_nxt = ptd_pkg::ST_IDLE;
      end
      default: state_nxt = ptd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ptd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ctl.take = in_valid;
      end
      ptd_pkg::ST_EXEC: begin
        if (!misuse) begin
          unique case (stat.cmd)
            ptd_pkg::CMD_INIT:  ctl.do_init  = 1'b1;
            ptd_pkg::CMD_TICK:  ctl.do_tick  = 1'b1;
            ptd_pkg::CMD_RUN:   ctl.do_run   = 1'b1;
            ptd_pkg::CMD_ACT:   ctl.do_act   = 1'b1;
            ptd_pkg::CMD_DEACT: ctl.do_deact = 1'b1;
            default: ;
          endcase
        end
      end
      ptd_pkg::ST_SCAN: begin
        if (stat.out_free) begin
          ctl.emit_hit  = !stat.mask_empty;
          ctl.emit_idle = stat.mask_empty;
        end
      end
      ptd_pkg::ST_FAULT: begin
        ctl.emit_fault = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/ptd_datapath.sv */
// task table, tick counter and result register of the dispatcher
`timescale 1ns / 1ps

module ptd_datapath #(
  parameter int NUM_TASKS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ptd_pkg::in_req_t                in_data,
  input  logic                            cfg_valid,
  input  logic [ptd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ptd_pkg::TICK_W-1:0]      cfg_data,
  input  ptd_pkg::ptd_cmd_t               ctl,
  output ptd_pkg::ptd_stat_t              stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ptd_pkg::out_rsp_t               out_data
);

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int TW = ptd_pkg::TICK_W;

  ptd_pkg::in_req_t  req_r;
  logic [TW-1:0]     offset_r [NUM_TASKS];
  logic [TW-1:0]     period_r [NUM_TASKS];
  logic [TW-1:0]     next_due_r [NUM_TASKS];
  logic [TW-1:0]     tick_r;
  logic              wrapped_r;
  logic              init_r;
  logic              halted_r;
  logic [NUM_TASKS-1:0] active_r;
  logic [NUM_TASKS-1:0] ovf_r;
  logic [NUM_TASKS-1:0] mask_r;
  logic              out_valid_r;
  ptd_pkg::out_rsp_t out_data_r;

  logic [NUM_TASKS-1:0] hit_w;
  logic [NUM_TASKS-1:0] low_w;
  logic [IDX_W-1:0]     sel_w;
  logic [TW:0]          sum_w;
  logic                 out_free;
  logic                 emit_any;
  ptd_pkg::out_rsp_t    rsp_nxt;

  // due check at pass start, with overflow marks dropped after a counter wrap
  always_comb begin
    for (int i = 0; i < NUM_TASKS; i++) begin
      hit_w[i] = active_r[i] && !(ovf_r[i] && !wrapped_r) && (tick_r >= next_due_r[i]);
    end
  end

  // lowest pending task of the pass
  assign low_w = mask_r & (~mask_r + NUM_TASKS'(1));

  always_comb begin
    sel_w = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (low_w[i]) sel_w = IDX_W'(i);
    end
  end

  assign sum_w = {1'b0, next_due_r[sel_w]} + {1'b0, period_r[sel_w]};

  assign out_free = !out_valid_r || out_ready;
  assign emit_any = ctl.emit_hit || ctl.emit_idle || ctl.emit_fault;

  always_comb begin
    rsp_nxt = '0;
    if (ctl.emit_hit) begin
      rsp_nxt.task_index_out = 2'(sel_w);
      rsp_nxt.due            = 1'b1;
      rsp_nxt.last           = ((mask_r & ~low_w) == '0);
    end else if (ctl.emit_fault) begin
      rsp_nxt.last  = 1'b1;
      rsp_nxt.fault = 1'b1;
    end else begin
      rsp_nxt.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      wrapped_r   <= 1'b0;
      init_r      <= 1'b0;
      halted_r    <= 1'b0;
      active_r    <= '0;
      ovf_r       <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        offset_r[i] <= '0;
        period_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        if (cfg_valid && cfg_index == ptd_pkg::CFG_IDX_W'(i)) offset_r[i] <= cfg_data;
        if (cfg_valid && cfg_index == ptd_pkg::CFG_IDX_W'(ptd_pkg::CFG_PERIOD_BASE + i)) begin
          period_r[i] <= cfg_data;
        end
        if (ctl.do_init) active_r[i] <= 1'b0;
        if (ctl.do_act && req_r.task_index == 2'(i)) active_r[i] <= 1'b1;
        if (ctl.do_deact && req_r.task_index == 2'(i)) active_r[i] <= 1'b0;
      end
      if (ctl.do_init) init_r <= 1'b1;
      if (ctl.do_tick) begin
        tick_r <= tick_r + TW'(1);
        if (tick_r == '1) wrapped_r <= 1'b1;
      end
      if (ctl.do_run) begin
        mask_r <= hit_w;
        if (wrapped_r) begin
          ovf_r     <= '0;
          wrapped_r <= 1'b0;
        end
      end
      if (ctl.emit_hit) begin
        mask_r <= mask_r & ~low_w;
        if (sum_w[TW]) ovf_r <= ovf_r | low_w;
      end
      if (ctl.emit_fault) halted_r <= 1'b1;
      if (emit_any) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) req_r <= in_data;
    if (emit_any) out_data_r <= rsp_nxt;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (ctl.do_init) next_due_r[i] <= offset_r[i];
      else if (ctl.emit_hit && low_w[i]) next_due_r[i] <= sum_w[TW-1:0];
    end
  end

  assign stat.cmd         = req_r.cmd;
  assign stat.halted      = halted_r;
  assign stat.initialized = init_r;
  assign stat.mask_empty  = (mask_r == '0);
  assign stat.mask_last   = ((mask_r & ~low_w) == '0);
  assign stat.out_free    = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/periodic_task_dispatcher.sv */
// top level of the periodic task dispatcher
//
//   channel  direction  handshake                payload
//   in_      request    in_valid / in_ready      in_data (cmd, task_index)
//   out_     result     out_valid / out_ready    out_data (task_index_out, due, last, fault)
//   cfg_     write      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// a request is taken in one state and decoded in the next, so commands without a
// result end once decoded; a run pass then gives one result per cycle unless
// stalled, one per due task (or one with due clear), set by the single next-due adder.
// reset is synchronous and active low and clears task and counter state except the next-due times.
// a held result stalls the pass; the result register frees as out_ready is seen.
`timescale 1ns / 1ps

module periodic_task_dispatcher #(
  parameter int NUM_TASKS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ptd_pkg::in_req_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ptd_pkg::out_rsp_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ptd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptd_pkg::TICK_W-1:0]    cfg_data
);

  ptd_pkg::ptd_cmd_t  ctl;
  ptd_pkg::ptd_stat_t stat;

  assign cfg_ready = 1'b1;

  ptd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  ptd_datapath #(
    .NUM_TASKS (NUM_TASKS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/ptd_chk.sv */
// port checker for the periodic task dispatcher
`timescale 1ns / 1ps

module ptd_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input ptd_pkg::out_rsp_t out_data
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_fault_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fault |-> out_data.last && !out_data.due)
    else $error("fault result malformed");

  a_idle_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.due |-> out_data.last && out_data.task_index_out == 2'd0)
    else $error("result without dispatch malformed");

  // a taken fault result is not directly followed by an ordinary result
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.fault |=> !(out_valid && !out_data.fault))
    else $error("result after halt");

endmodule

bind periodic_task_dispatcher ptd_chk u_ptd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* sim/tb_periodic_task_dispatcher.sv */
// self-checking testbench for the periodic task dispatcher
`timescale 1ns / 1ps

module tb_periodic_task_dispatcher;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 110;

  // command codes the block does not act on, unless halted
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  localparam int REG_OFFSET_BASE = 0;
  localparam int REG_FIRST_UNUSED = 8;

  typedef logic [ptd_pkg::CFG_IDX_W-1:0] reg_idx_t;
  typedef logic [ptd_pkg::TICK_W-1:0] tick_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ptd_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ptd_pkg::out_rsp_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  reg_idx_t cfg_index = '0;
  tick_t cfg_data = '0;

  // idling controls, set by the tests
  int send_gap_pct = 0;
  int stall_pct = 0;
  int hold_off_seq = 0;
  int hold_off_seen = 0;
  int hold_left = 0;

  int error_count = 0;
  int idle_cycles = 0;

  // dispatcher image kept by the testbench
  tick_t offset_cfg [4];
  tick_t period_cfg [4];
  tick_t tick_now;
  tick_t due_at [4];
  logic [3:0] armed;
  logic [3:0] due_wrapped;
  logic wrap_seen;
  logic sched_started;
  logic sched_halted;

  ptd_pkg::out_rsp_t expected_dispatches [$];

  periodic_task_dispatcher #(
    .NUM_TASKS(4)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_off_seq != hold_off_seen) begin
      hold_off_seen <= hold_off_seq;
      hold_left <= HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    ptd_pkg::out_rsp_t exp_rsp;
    if (rst_n && out_valid && out_ready) begin
      if (expected_dispatches.size() == 0) begin
        $error("unexpected result %p", out_data);
        error_count++;
      end else begin
        exp_rsp = expected_dispatches.pop_front();
        if (out_data.task_index_out !== exp_rsp.task_index_out) begin
          $error("task_index_out: expected %0d, got %0d",
                 exp_rsp.task_index_out, out_data.task_index_out);
          error_count++;
        end
        if (out_data.due !== exp_rsp.due) begin
          $error("due: expected %0b, got %0b", exp_rsp.due, out_data.due);
          error_count++;
        end
        if (out_data.last !== exp_rsp.last) begin
          $error("last: expected %0b, got %0b", exp_rsp.last, out_data.last);
          error_count++;
        end
        if (out_data.fault !== exp_rsp.fault) begin
          $error("fault: expected %0b, got %0b", exp_rsp.fault, out_data.fault);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_fault();
    ptd_pkg::out_rsp_t rsp;
    sched_halted = 1'b1;
    rsp = '{task_index_out: 2'd0, due: 1'b0, last: 1'b1, fault: 1'b1};
    expected_dispatches.push_back(rsp);
  endtask

  // advance the image by one accepted request and queue what it dispatches
  task automatic predict_dispatch(input ptd_pkg::in_req_t req);
    ptd_pkg::out_rsp_t pass_rsp [$];
    ptd_pkg::out_rsp_t rsp;
    if (sched_halted) begin
      push_fault();
      return;
    end
    case (req.cmd)
      ptd_pkg::CMD_INIT: begin
        if (sched_started) begin
          push_fault();
        end else begin
          for (int i = 0; i < 4; i++) due_at[i] = offset_cfg[i];
          armed = '0;
          sched_started = 1'b1;
        end
      end
      ptd_pkg::CMD_TICK: begin
        if (!sched_started) begin
          push_fault();
        end else begin
          tick_now = tick_now + 1'b1;
          if (tick_now == '0) wrap_seen = 1'b1;
        end
      end
      ptd_pkg::CMD_RUN: begin
        if (!sched_started) begin
          push_fault();
        end else begin
          if (wrap_seen) begin
            due_wrapped = '0;
            wrap_seen = 1'b0;
          end
          for (int i = 0; i < 4; i++) begin
            if (armed[i] && !due_wrapped[i] && tick_now >= due_at[i]) begin
              due_at[i] = due_at[i] + period_cfg[i];
              if (due_at[i] < period_cfg[i]) due_wrapped[i] = 1'b1;
              rsp = '{task_index_out: 2'(i), due: 1'b1, last: 1'b0, fault: 1'b0};
              pass_rsp.push_back(rsp);
            end
          end
          if (pass_rsp.size() == 0) begin
            rsp = '{task_index_out: 2'd0, due: 1'b0, last: 1'b1, fault: 1'b0};
            pass_rsp.push_back(rsp);
          end
          pass_rsp[pass_rsp.size() - 1].last = 1'b1;
          foreach (pass_rsp[k]) expected_dispatches.push_back(pass_rsp[k]);
        end
      end
      ptd_pkg::CMD_ACT: begin
        if (!sched_started) push_fault();
        else armed[req.task_index] = 1'b1;
      end
      ptd_pkg::CMD_DEACT: armed[req.task_index] = 1'b0;
      default: ;
    endcase
  endtask

  // valid stays high across back-to-back requests; only a gap or settle lowers it
  task automatic send_request(input logic [2:0] cmd, input int idx);
    ptd_pkg::in_req_t req;
    req = '{cmd: cmd, task_index: 2'(idx)};
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    predict_dispatch(req);
  endtask

  task automatic write_reg(input int idx, input int value);
    reg_idx_t ridx;
    tick_t rval;
    ridx = reg_idx_t'(idx);
    rval = tick_t'(value);
    cfg_valid <= 1'b1;
    cfg_index <= ridx;
    cfg_data <= rval;
    do @(posedge clk); while (!cfg_ready);
    if (idx < ptd_pkg::CFG_PERIOD_BASE) begin
      offset_cfg[2'(idx - REG_OFFSET_BASE)] = rval;
    end else if (idx < REG_FIRST_UNUSED) begin
      period_cfg[2'(idx - ptd_pkg::CFG_PERIOD_BASE)] = rval;
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until the block has delivered everything and gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_dispatches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_periods(input int max_period);
    for (int i = 0; i < 4; i++) begin
      write_reg(ptd_pkg::CFG_PERIOD_BASE + i, int'($urandom_range(max_period)));
    end
    write_reg(int'($urandom_range(15, REG_FIRST_UNUSED)), int'($urandom_range(16'hFFFF)));
  endtask

  task automatic test_config_and_pre_init();
    // all ones first, including indexes past the register file
    for (int i = 0; i < 16; i++) write_reg(i, 16'hFFFF);
    write_reg(REG_OFFSET_BASE + 0, 16'd0);
    write_reg(REG_OFFSET_BASE + 1, 16'd2);
    write_reg(REG_OFFSET_BASE + 2, 16'hFFFF);
    write_reg(REG_OFFSET_BASE + 3, 16'd5);
    write_reg(ptd_pkg::CFG_PERIOD_BASE + 0, 16'd0);
    write_reg(ptd_pkg::CFG_PERIOD_BASE + 1, 16'd3);
    write_reg(ptd_pkg::CFG_PERIOD_BASE + 2, 16'd0);
    write_reg(ptd_pkg::CFG_PERIOD_BASE + 3, 16'hFFFF);
    // deactivate is legal before init, unused codes are dropped
    for (int i = 0; i < 4; i++) send_request(ptd_pkg::CMD_DEACT, i);
    send_request(CMD_RSVD5, 3);
    send_request(CMD_RSVD6, 3);
    send_request(CMD_RSVD7, 3);
    settle();
  endtask

  task automatic test_directed_dispatch();
    send_request(ptd_pkg::CMD_INIT, 0);
    send_request(ptd_pkg::CMD_RUN, 0);
    for (int i = 0; i < 4; i++) send_request(ptd_pkg::CMD_ACT, i);
    send_request(ptd_pkg::CMD_RUN, 0);
    repeat (5) send_request(ptd_pkg::CMD_TICK, 0);
    // task 3 advances past the top of the counter here and stays parked
    send_request(ptd_pkg::CMD_RUN, 0);
    send_request(ptd_pkg::CMD_TICK, 0);
    send_request(ptd_pkg::CMD_RUN, 0);
    send_request(ptd_pkg::CMD_DEACT, 0);
    send_request(ptd_pkg::CMD_RUN, 0);
    settle();
  endtask

  task automatic test_random_traffic(input int n_items, input int gap_pct, input int stall);
    int sent;
    int pick;
    sent = 0;
    send_gap_pct = gap_pct;
    stall_pct = stall;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_request(ptd_pkg::CMD_TICK, int'($urandom_range(3)));
      end else if (pick < 72) begin
        send_request(ptd_pkg::CMD_RUN, int'($urandom_range(3)));
      end else if (pick < 84) begin
        send_request(ptd_pkg::CMD_ACT, int'($urandom_range(3)));
      end else if (pick < 94) begin
        send_request(ptd_pkg::CMD_DEACT, int'($urandom_range(3)));
      end else begin
        send_request(3'(CMD_RSVD5 + $urandom_range(2)), int'($urandom_range(3)));
        sent--;
      end
      sent++;
    end
    settle();
  endtask

  task automatic test_backpressure();
    send_gap_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < 4; i++) write_reg(ptd_pkg::CFG_PERIOD_BASE + i, 16'd0);
    for (int i = 0; i < 4; i++) send_request(ptd_pkg::CMD_ACT, i);
    send_request(ptd_pkg::CMD_TICK, 0);
    hold_off_seq <= hold_off_seq + 1;
    repeat (30) send_request(ptd_pkg::CMD_RUN, 0);
    settle();
  endtask

  // large periods push due times past the top of the counter
  task automatic test_due_overflow();
    send_gap_pct = 0;
    stall_pct = 0;
    write_reg(ptd_pkg::CFG_PERIOD_BASE + 0, 16'hC000);
    write_reg(ptd_pkg::CFG_PERIOD_BASE + 1, 16'h8000);
    write_reg(ptd_pkg::CFG_PERIOD_BASE + 2, 16'd0);
    write_reg(ptd_pkg::CFG_PERIOD_BASE + 3, 16'd1);
    for (int i = 0; i < 4; i++) send_request(ptd_pkg::CMD_ACT, i);
    repeat (12) begin
      repeat (3) send_request(ptd_pkg::CMD_TICK, 0);
      send_request(ptd_pkg::CMD_RUN, 0);
    end
    settle();
  endtask

  task automatic test_misuse_halt();
    send_gap_pct = 10;
    stall_pct = 10;
    send_request(ptd_pkg::CMD_INIT, 0);
    repeat (8) send_request(3'($urandom_range(7)), int'($urandom_range(3)));
    settle();
  endtask

  initial begin
    for (int i = 0; i < 4; i++) begin
      offset_cfg[i] = '0;
      period_cfg[i] = '0;
      due_at[i] = '0;
    end
    tick_now = '0;
    armed = '0;
    due_wrapped = '0;
    wrap_seen = 1'b0;
    sched_started = 1'b0;
    sched_halted = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_gap_pct = 10;
    stall_pct = 64;
    test_config_and_pre_init();
    test_directed_dispatch();

    load_periods(6);
    test_random_traffic(RANDOM_ITEMS, 10, 64);

    write_reg(ptd_pkg::CFG_PERIOD_BASE + 0, 16'd0);
    write_reg(ptd_pkg::CFG_PERIOD_BASE + 1, 16'hFFFF);
    write_reg(ptd_pkg::CFG_PERIOD_BASE + 2, int'($urandom_range(8)));
    write_reg(ptd_pkg::CFG_PERIOD_BASE + 3, int'($urandom_range(8)));
    write_reg(REG_OFFSET_BASE + int'($urandom_range(3)), 16'd0);
    test_random_traffic(RANDOM_ITEMS, 64, 10);

    load_periods(10);
    test_random_traffic(RANDOM_ITEMS, 0, 0);

    test_backpressure();
    test_due_overflow();
    test_misuse_halt();

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
